FILE: rtl/core/spwd_pkg.sv
// Shared types and constants for the stall progress watchdog.
// No dependencies; every other file of the block imports this package.
package spwd_pkg;

    localparam int COUNT_WIDTH    = 48;
    localparam int ACTIVE_WIDTH   = 16;
    localparam int SESSION_WIDTH  = 10;
    localparam int INTERVAL_WIDTH = 16;
    localparam int ELAPSED_WIDTH  = 17;
    localparam int TOTAL_WIDTH    = 32;

    localparam logic [INTERVAL_WIDTH-1:0] INTERVAL_RESET = INTERVAL_WIDTH'(1000);
    localparam logic [ELAPSED_WIDTH-1:0]  ELAPSED_MAX    = '1;
    localparam logic [TOTAL_WIDTH-1:0]    TOTAL_MAX      = '1;

    // Item kind codes
    typedef enum logic {
        KIND_TICK  = 1'b0,
        KIND_START = 1'b1
    } kind_t;

    // One input item as held in the input register
    typedef struct packed {
        kind_t                    kind;
        logic [COUNT_WIDTH-1:0]   applied_events;
        logic [COUNT_WIDTH-1:0]   sched_clock;
        logic [COUNT_WIDTH-1:0]   commit_clock;
        logic [ACTIVE_WIDTH-1:0]  active_tasks;
        logic [SESSION_WIDTH-1:0] session_count;
    } item_t;

    // Input register contents handed to the check stage
    typedef struct packed {
        logic  valid;
        item_t item;
    } stage_t;

    // One result item as held in the output register
    typedef struct packed {
        logic                     unblock_request;
        logic                     sampled;
        logic [SESSION_WIDTH-1:0] allowed_unblocks;
        logic [SESSION_WIDTH-1:0] current_unblocks;
        logic [TOTAL_WIDTH-1:0]   total_unblocks;
    } result_t;

endpackage

FILE: rtl/core/spwd_in_if.sv
// Input channel of the stall progress watchdog: valid/ready plus item fields.
// Depends on spwd_pkg for field widths.
interface spwd_in_if;
    import spwd_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     kind;
    logic [COUNT_WIDTH-1:0]   applied_events;
    logic [COUNT_WIDTH-1:0]   sched_clock;
    logic [COUNT_WIDTH-1:0]   commit_clock;
    logic [ACTIVE_WIDTH-1:0]  active_tasks;
    logic [SESSION_WIDTH-1:0] session_count;

    modport source (
        output valid, kind, applied_events, sched_clock, commit_clock,
               active_tasks, session_count,
        input  ready
    );

    modport sink (
        input  valid, kind, applied_events, sched_clock, commit_clock,
               active_tasks, session_count,
        output ready
    );
endinterface

FILE: rtl/core/spwd_out_if.sv
// Result channel of the stall progress watchdog: valid/ready plus result fields.
// Depends on spwd_pkg for field widths.
interface spwd_out_if;
    import spwd_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     unblock_request;
    logic                     sampled;
    logic [SESSION_WIDTH-1:0] allowed_unblocks;
    logic [SESSION_WIDTH-1:0] current_unblocks;
    logic [TOTAL_WIDTH-1:0]   total_unblocks;

    modport source (
        output valid, unblock_request, sampled, allowed_unblocks,
               current_unblocks, total_unblocks,
        input  ready
    );

    modport sink (
        input  valid, unblock_request, sampled, allowed_unblocks,
               current_unblocks, total_unblocks,
        output ready
    );
endinterface

FILE: rtl/core/spwd_in_stage.sv
// Input register of the stall progress watchdog.
// Depends on spwd_pkg and spwd_in_if; feeds spwd_check.
module spwd_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    spwd_in_if.sink           tick_in,
    input  logic              advance,
    output spwd_pkg::stage_t  stage
);
    import spwd_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    item_t item_next;
    logic  accept;

    // Take a transaction when empty or when the held one moves on
    assign tick_in.ready = !valid_reg || advance;
    assign accept        = tick_in.valid && tick_in.ready;

    // Hold, refill or drain the input register
    always_comb
    begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (accept)
        begin
            valid_next               = 1'b1;
            item_next.kind           = kind_t'(tick_in.kind);
            item_next.applied_events = tick_in.applied_events;
            item_next.sched_clock    = tick_in.sched_clock;
            item_next.commit_clock   = tick_in.commit_clock;
            item_next.active_tasks   = tick_in.active_tasks;
            item_next.session_count  = tick_in.session_count;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset
    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign stage.valid = valid_reg;
    assign stage.item  = item_reg;

endmodule

FILE: rtl/core/spwd_check.sv
// Progress check, watchdog state and result register.
// Depends on spwd_pkg and spwd_out_if; driven by spwd_in_stage.
module spwd_check (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [spwd_pkg::INTERVAL_WIDTH-1:0] cfg_wdata,
    input  spwd_pkg::stage_t                    stage,
    output logic                                advance,
    spwd_out_if.source                          result_out
);
    import spwd_pkg::*;

    logic [INTERVAL_WIDTH-1:0] interval_reg;
    logic [ELAPSED_WIDTH-1:0]  elapsed_reg;
    logic [ELAPSED_WIDTH-1:0]  elapsed_next;
    logic [COUNT_WIDTH-1:0]    cur_events_reg;
    logic [COUNT_WIDTH-1:0]    cur_sched_clock_reg;
    logic [COUNT_WIDTH-1:0]    cur_commit_clock_reg;
    logic                      sample_en;
    logic [SESSION_WIDTH-1:0]  unblock_limit_reg;
    logic [SESSION_WIDTH-1:0]  unblock_limit_next;
    logic [SESSION_WIDTH-1:0]  unblocks_now_reg;
    logic [SESSION_WIDTH-1:0]  unblocks_now_next;
    logic [TOTAL_WIDTH-1:0]    unblocks_total_reg;
    logic [TOTAL_WIDTH-1:0]    unblocks_total_next;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    result_t                   result_reg;
    result_t                   result_next;

    logic [ELAPSED_WIDTH-1:0]  elapsed_inc;
    logic [SESSION_WIDTH-1:0]  limit_tick;
    logic                      due;
    logic                      events_up;
    logic                      sched_up;
    logic                      commit_up;
    logic                      idle_tasks;
    logic                      progress;
    logic                      request;

    // Move the held item into the result register when that slot frees up
    assign advance = stage.valid && (!out_valid_reg || result_out.ready);

    // Tick time base and limit latch
    assign elapsed_inc = (elapsed_reg == ELAPSED_MAX) ? elapsed_reg : elapsed_reg + 1'b1;
    assign limit_tick  = (unblock_limit_reg == '0) ? stage.item.session_count
                                                   : unblock_limit_reg;
    assign due         = elapsed_inc >= ELAPSED_WIDTH'(interval_reg);

    // Compare the new sample against the stored one
    assign events_up  = stage.item.applied_events > cur_events_reg;
    assign sched_up   = stage.item.sched_clock > cur_sched_clock_reg;
    assign commit_up  = stage.item.commit_clock > cur_commit_clock_reg;
    assign idle_tasks = stage.item.active_tasks == '0;

    always_comb
    begin
        if (unblocks_now_reg != '0)
        begin
            progress = events_up || idle_tasks;
        end
        else
        begin
            progress = idle_tasks || sched_up || events_up || commit_up;
        end
    end

    // Work out the next watchdog state for the held item
    always_comb
    begin
        elapsed_next        = elapsed_reg;
        sample_en           = 1'b0;
        unblock_limit_next  = unblock_limit_reg;
        unblocks_now_next   = unblocks_now_reg;
        unblocks_total_next = unblocks_total_reg;
        request             = 1'b0;
        unique case (stage.item.kind)
            KIND_START:
            begin
                elapsed_next = '0;
                sample_en    = 1'b1;
            end
            KIND_TICK:
            begin
                unblock_limit_next = limit_tick;
                if (due)
                begin
                    elapsed_next = '0;
                    sample_en    = 1'b1;
                    if (progress)
                    begin
                        unblocks_now_next = '0;
                    end
                    else if (unblocks_now_reg < limit_tick)
                    begin
                        request           = 1'b1;
                        unblocks_now_next = unblocks_now_reg + 1'b1;
                        if (unblocks_total_reg != TOTAL_MAX)
                        begin
                            unblocks_total_next = unblocks_total_reg + 1'b1;
                        end
                    end
                end
                else
                begin
                    elapsed_next = elapsed_inc;
                end
            end
            default:
            begin
                elapsed_next = elapsed_reg;
            end
        endcase
    end

    // Build the result and drain the output register
    always_comb
    begin
        result_next.unblock_request  = request;
        result_next.sampled          = sample_en;
        result_next.allowed_unblocks = unblock_limit_next;
        result_next.current_unblocks = unblocks_now_next;
        result_next.total_unblocks   = unblocks_total_next;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_out.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg         <= INTERVAL_RESET;
            elapsed_reg          <= '0;
            cur_events_reg       <= '0;
            cur_sched_clock_reg  <= '0;
            cur_commit_clock_reg <= '0;
            unblock_limit_reg    <= '0;
            unblocks_now_reg     <= '0;
            unblocks_total_reg   <= '0;
            out_valid_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                interval_reg <= cfg_wdata;
            end
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                elapsed_reg        <= elapsed_next;
                unblock_limit_reg  <= unblock_limit_next;
                unblocks_now_reg   <= unblocks_now_next;
                unblocks_total_reg <= unblocks_total_next;
                if (sample_en)
                begin
                    cur_events_reg       <= stage.item.applied_events;
                    cur_sched_clock_reg  <= stage.item.sched_clock;
                    cur_commit_clock_reg <= stage.item.commit_clock;
                end
            end
        end
    end

    // Result payload needs no reset
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign result_out.valid            = out_valid_reg;
    assign result_out.unblock_request  = result_reg.unblock_request;
    assign result_out.sampled          = result_reg.sampled;
    assign result_out.allowed_unblocks = result_reg.allowed_unblocks;
    assign result_out.current_unblocks = result_reg.current_unblocks;
    assign result_out.total_unblocks   = result_reg.total_unblocks;

    // Consecutive requests never pass the latched limit
    a_now_within_limit: assert property (@(posedge clk) disable iff (!rst_n)
        unblocks_now_reg <= unblock_limit_reg)
        else $error("unblock count above latched limit");

    // A latched limit is never replaced
    a_limit_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        (unblock_limit_reg != '0) |=> $stable(unblock_limit_reg))
        else $error("latched unblock limit changed");

    // An unblock request only comes with a fresh sample
    a_request_on_sample: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_reg.unblock_request) |-> result_reg.sampled)
        else $error("unblock request without sample");

    // The total count never falls
    a_total_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> unblocks_total_reg >= $past(unblocks_total_reg))
        else $error("total unblock count decreased");

endmodule

FILE: rtl/core/stall_progress_watchdog_unit.sv
// Flow: a transaction accepted into the input register is checked and loaded into the
// result register once that register is free, and its result is taken from there.
// Throughput: one transaction per cycle; the input side keeps taking items while a
// result waits, stalling only when both registers are full and the result is held.
// Reset (rst_n, asynchronous, active low) clears all counters and samples to zero
// and sets the refresh interval to 1000 ticks. Depends on spwd_pkg and the interfaces.
module stall_progress_watchdog_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    spwd_in_if.sink                             tick_in,
    spwd_out_if.source                          result_out,
    input  logic                                cfg_we,
    input  logic [spwd_pkg::INTERVAL_WIDTH-1:0] cfg_wdata
);
    import spwd_pkg::*;

    stage_t stage;
    logic   advance;

    // Input register
    spwd_in_stage u_in_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .tick_in (tick_in),
        .advance (advance),
        .stage   (stage)
    );

    // Check logic, watchdog state and result register
    spwd_check u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .stage      (stage),
        .advance    (advance),
        .result_out (result_out)
    );

endmodule

FILE: sim/stall_progress_watchdog_unit_test.sv
// Testbench for stall_progress_watchdog_unit: directed and random tick/start traffic
// checked against an in-bench model of the watchdog. Depends on spwd_pkg,
// spwd_in_if, spwd_out_if and the unit itself.
`timescale 1ns / 100ps

module stall_progress_watchdog_unit_test;
    import spwd_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam logic [COUNT_WIDTH-1:0] COUNT_ALL_ONES = '1;
    localparam logic [ACTIVE_WIDTH-1:0] ACTIVE_MAX = '1;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [INTERVAL_WIDTH-1:0] cfg_wdata;

    spwd_in_if  tick_if();
    spwd_out_if result_if();

    stall_progress_watchdog_unit i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick_in    (tick_if),
        .result_out (result_if),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata)
    );

    // Watchdog model state
    logic [INTERVAL_WIDTH-1:0] wd_interval;
    logic [ELAPSED_WIDTH-1:0]  wd_elapsed;
    logic [COUNT_WIDTH-1:0]    wd_prev_events, wd_cur_events;
    logic [COUNT_WIDTH-1:0]    wd_prev_sched, wd_cur_sched;
    logic [COUNT_WIDTH-1:0]    wd_prev_commit, wd_cur_commit;
    logic [ACTIVE_WIDTH-1:0]   wd_active;
    logic [SESSION_WIDTH-1:0]  wd_limit;
    logic [SESSION_WIDTH-1:0]  wd_unblocks;
    logic [TOTAL_WIDTH-1:0]    wd_total;

    // Live workload counters that the random traffic evolves
    logic [COUNT_WIDTH-1:0]  live_events, live_sched, live_commit;
    logic [ACTIVE_WIDTH-1:0] live_active;

    result_t expected_reports[$];
    bit      idle_on;
    int      hold_request;
    int      hold_left;
    int      cycle_count;
    int      error_count;
    int      items_sent;
    int      reports_checked;
    int      samples_seen;
    int      requests_seen;

    // Clock and cycle limit
    initial clk = 1'b0;
    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("stall_progress_watchdog_unit: mismatch");
            $finish;
        end
    end

    // Shift the current sample to previous and capture the live values
    function automatic void shift_sample(input item_t it);
        wd_prev_events = wd_cur_events;
        wd_prev_sched  = wd_cur_sched;
        wd_prev_commit = wd_cur_commit;
        wd_cur_events  = it.applied_events;
        wd_cur_sched   = it.sched_clock;
        wd_cur_commit  = it.commit_clock;
        wd_active      = it.active_tasks;
    endfunction

    // Advance the watchdog by one transaction and return the report it produces
    function automatic result_t advance_watchdog(input item_t it);
        result_t r;
        logic    progress;
        r = '0;
        if (it.kind == KIND_START)
        begin
            wd_elapsed = '0;
            shift_sample(it);
            r.sampled = 1'b1;
        end
        else
        begin
            if (wd_elapsed != ELAPSED_MAX)
                wd_elapsed++;
            if (wd_limit == '0)
                wd_limit = it.session_count;
            if (wd_elapsed >= {1'b0, wd_interval})
            begin
                shift_sample(it);
                r.sampled  = 1'b1;
                wd_elapsed = '0;
                // While unblocking, only event progress or an empty pool counts
                if (wd_unblocks != '0)
                    progress = (wd_cur_events > wd_prev_events) || (wd_active == '0);
                else
                    progress = (wd_active == '0) || (wd_cur_sched > wd_prev_sched) ||
                               (wd_cur_events > wd_prev_events) ||
                               (wd_cur_commit > wd_prev_commit);
                if (progress)
                    wd_unblocks = '0;
                else if (wd_unblocks < wd_limit)
                begin
                    r.unblock_request = 1'b1;
                    wd_unblocks++;
                    if (wd_total != TOTAL_MAX)
                        wd_total++;
                end
            end
        end
        r.allowed_unblocks = wd_limit;
        r.current_unblocks = wd_unblocks;
        r.total_unblocks   = wd_total;
        return r;
    endfunction

    function automatic logic [COUNT_WIDTH-1:0] rand_count();
        return COUNT_WIDTH'({$urandom, $urandom});
    endfunction

    function automatic item_t make_item(input kind_t kind,
                                        input logic [COUNT_WIDTH-1:0] events,
                                        input logic [COUNT_WIDTH-1:0] sched,
                                        input logic [COUNT_WIDTH-1:0] commit,
                                        input logic [ACTIVE_WIDTH-1:0] active,
                                        input logic [SESSION_WIDTH-1:0] sessions);
        item_t it;
        it.kind           = kind;
        it.applied_events = events;
        it.sched_clock    = sched;
        it.commit_clock   = commit;
        it.active_tasks   = active;
        it.session_count  = sessions;
        return it;
    endfunction

    // Evolve the live workload; freeze_pct sets how often the counters stay still
    function automatic item_t next_workload_item(input int freeze_pct);
        item_t it;
        if ($urandom_range(99) >= freeze_pct)
        begin
            case ($urandom_range(6))
                0: live_events = live_events + $urandom_range(1, 50);
                1: live_sched  = live_sched + $urandom_range(1, 50);
                2: live_commit = live_commit + $urandom_range(1, 50);
                3: live_active = '0;
                4: live_active = ACTIVE_WIDTH'($urandom_range(1, 65535));
                5: live_events = live_events - $urandom_range(1, 1000);
                default:
                begin
                    live_events = rand_count();
                    live_sched  = rand_count();
                    live_commit = rand_count();
                end
            endcase
        end
        else if (live_active == '0 && $urandom_range(1) == 1)
            live_active = ACTIVE_WIDTH'($urandom_range(1, 65535));
        it = make_item(($urandom_range(99) < 4) ? KIND_START : KIND_TICK,
                       live_events, live_sched, live_commit, live_active,
                       SESSION_WIDTH'($urandom_range(1023)));
        // Occasional noise transaction; leave the live workload untouched
        if ($urandom_range(99) < 8)
            it = make_item(kind_t'($urandom_range(1)), rand_count(), rand_count(),
                           rand_count(), ACTIVE_WIDTH'($urandom),
                           SESSION_WIDTH'($urandom));
        return it;
    endfunction

    // Offer one transaction, hold it until accepted, then predict its report
    task automatic send_item(input item_t it);
        @(negedge clk);
        while (idle_on && $urandom_range(99) < 33)
        begin
            tick_if.valid <= 1'b0;
            @(negedge clk);
        end
        tick_if.kind           <= it.kind;
        tick_if.applied_events <= it.applied_events;
        tick_if.sched_clock    <= it.sched_clock;
        tick_if.commit_clock   <= it.commit_clock;
        tick_if.active_tasks   <= it.active_tasks;
        tick_if.session_count  <= it.session_count;
        tick_if.valid          <= 1'b1;
        do
            @(posedge clk);
        while (tick_if.ready !== 1'b1);
        expected_reports.push_back(advance_watchdog(it));
        items_sent++;
    endtask

    // Drop valid and wait until every report is back and the pipeline is empty
    task automatic wait_drained();
        @(negedge clk);
        tick_if.valid <= 1'b0;
        while (expected_reports.size() != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic set_interval(input logic [INTERVAL_WIDTH-1:0] value);
        wait_drained();
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(negedge clk);
        cfg_we      <= 1'b0;
        wd_interval = value;
    endtask

    // Receiver: random stalls, plus long hold-offs on request
    always @(negedge clk)
    begin
        if (hold_request != 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0)
        begin
            result_if.ready <= 1'b0;
            hold_left--;
        end
        else
            result_if.ready <= !(idle_on && $urandom_range(99) < 33);
    end

    // Compare each accepted report with the oldest prediction
    always @(posedge clk)
    begin
        result_t exp_r;
        if (rst_n && result_if.valid === 1'b1 && result_if.ready === 1'b1)
        begin
            if (expected_reports.size() == 0)
            begin
                $error("report with no transaction outstanding");
                error_count++;
            end
            else
            begin
                exp_r = expected_reports.pop_front();
                reports_checked++;
                samples_seen  += result_if.sampled;
                requests_seen += result_if.unblock_request;
                if (result_if.unblock_request !== exp_r.unblock_request)
                begin
                    $error("unblock_request: expected %0d, got %0d",
                           exp_r.unblock_request, result_if.unblock_request);
                    error_count++;
                end
                if (result_if.sampled !== exp_r.sampled)
                begin
                    $error("sampled: expected %0d, got %0d",
                           exp_r.sampled, result_if.sampled);
                    error_count++;
                end
                if (result_if.allowed_unblocks !== exp_r.allowed_unblocks)
                begin
                    $error("allowed_unblocks: expected %0d, got %0d",
                           exp_r.allowed_unblocks, result_if.allowed_unblocks);
                    error_count++;
                end
                if (result_if.current_unblocks !== exp_r.current_unblocks)
                begin
                    $error("current_unblocks: expected %0d, got %0d",
                           exp_r.current_unblocks, result_if.current_unblocks);
                    error_count++;
                end
                if (result_if.total_unblocks !== exp_r.total_unblocks)
                begin
                    $error("total_unblocks: expected %0d, got %0d",
                           exp_r.total_unblocks, result_if.total_unblocks);
                    error_count++;
                end
            end
        end
    end

    // Walk the corner cases: zero limit, latch, limit reached, progress rules, wrap
    task automatic test_directed();
        send_item(make_item(KIND_START, 5, 5, 5, 2, 0));
        send_item(make_item(KIND_TICK, 5, 5, 5, 2, 0));
        set_interval(0);
        send_item(make_item(KIND_TICK, 5, 5, 5, 2, 0));
        send_item(make_item(KIND_TICK, 5, 5, 5, 2, 3));
        send_item(make_item(KIND_TICK, 5, 6, 5, 2, 1023));
        send_item(make_item(KIND_TICK, 5, 6, 6, 2, 0));
        send_item(make_item(KIND_TICK, 5, 6, 6, 2, 512));
        send_item(make_item(KIND_TICK, 6, 6, 6, 2, 0));
        send_item(make_item(KIND_TICK, 6, 7, 6, 2, 0));
        send_item(make_item(KIND_TICK, 6, 7, 7, 2, 0));
        send_item(make_item(KIND_TICK, 6, 7, 7, ACTIVE_MAX, 0));
        send_item(make_item(KIND_TICK, 6, 7, 7, 0, 0));
        send_item(make_item(KIND_TICK, COUNT_ALL_ONES, COUNT_ALL_ONES, COUNT_ALL_ONES,
                            1, 0));
        send_item(make_item(KIND_TICK, 0, 0, 0, 1, 0));
        send_item(make_item(KIND_TICK, 0, COUNT_ALL_ONES, COUNT_ALL_ONES, 1, 0));
        set_interval(2);
        send_item(make_item(KIND_TICK, 1, 0, 0, 1, 0));
        send_item(make_item(KIND_TICK, 2, 0, 0, 1, 0));
        send_item(make_item(KIND_TICK, 3, 0, 0, 1, 0));
        send_item(make_item(KIND_START, 3, 0, 0, 1, 0));
        send_item(make_item(KIND_TICK, 3, 0, 0, 1, 0));
        set_interval(16'hFFFF);
        send_item(make_item(KIND_TICK, 3, 0, 0, 1, 0));
        send_item(make_item(KIND_TICK, 3, 0, 0, 1, 0));
        send_item(make_item(KIND_START, 9, 9, 9, 0, 0));
    endtask

    task automatic run_random_phase(input logic [INTERVAL_WIDTH-1:0] interval,
                                    input int count, input int freeze_pct);
        set_interval(interval);
        repeat (count)
            send_item(next_workload_item(freeze_pct));
    endtask

    task automatic test_random_workload();
        run_random_phase(1, 300, 60);
        run_random_phase(3, 300, 75);
        // Long stretch with no idling on either side
        idle_on = 1'b0;
        run_random_phase(0, 200, 50);
        idle_on = 1'b1;
        run_random_phase(7, 250, 90);
        run_random_phase(16'hFFFF, 40, 50);
    endtask

    // Hold the receiver off while the sender keeps offering transactions
    task automatic test_receiver_backpressure();
        set_interval(1);
        @(posedge clk);
        hold_request = 80;
        repeat (60)
            send_item(next_workload_item(70));
    endtask

    // Pause the sender until every report has come back, then resume
    task automatic test_sender_pause();
        set_interval(0);
        repeat (30)
            send_item(next_workload_item(60));
        wait_drained();
        repeat (30)
            send_item(next_workload_item(60));
    endtask

    initial
    begin
        rst_n                  = 1'b0;
        cfg_we                 = 1'b0;
        cfg_wdata              = '0;
        tick_if.valid          = 1'b0;
        tick_if.kind           = KIND_TICK;
        tick_if.applied_events = '0;
        tick_if.sched_clock    = '0;
        tick_if.commit_clock   = '0;
        tick_if.active_tasks   = '0;
        tick_if.session_count  = '0;
        result_if.ready        = 1'b0;
        idle_on                = 1'b1;
        hold_request           = 0;
        hold_left              = 0;
        cycle_count            = 0;
        error_count            = 0;
        items_sent             = 0;
        reports_checked        = 0;
        samples_seen           = 0;
        requests_seen          = 0;
        wd_interval            = INTERVAL_RESET;
        wd_elapsed             = '0;
        wd_prev_events         = '0;
        wd_cur_events          = '0;
        wd_prev_sched          = '0;
        wd_cur_sched           = '0;
        wd_prev_commit         = '0;
        wd_cur_commit          = '0;
        wd_active              = '0;
        wd_limit               = '0;
        wd_unblocks            = '0;
        wd_total               = '0;
        live_events            = '0;
        live_sched             = '0;
        live_commit            = '0;
        live_active            = 5;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random_workload();
        test_receiver_backpressure();
        test_sender_pause();

        // Drain and let the pipeline settle
        wait_drained();
        repeat (4) @(posedge clk);
        if (expected_reports.size() != 0)
        begin
            $error("%0d reports never arrived", expected_reports.size());
            error_count++;
        end

        $display("Sent %0d tick/start transactions over intervals 1000, 0, 1, 2, 3, 7, 65535;",
                 items_sent);
        $display("checked %0d reports: %0d samples, %0d unblock requests.",
                 reports_checked, samples_seen, requests_seen);
        if (error_count == 0)
            $display("stall_progress_watchdog_unit: match");
        else
            $display("stall_progress_watchdog_unit: mismatch");
        $finish;
    end

endmodule
